// ----- src/kcsb_pkg.sv -----
package kcsb_pkg;

    // One sample of the keyboard bus plus the byte that the host side offers.
    typedef struct packed {
        logic       clock_level;
        logic       scan_enable;
        logic [3:0] column_lines;
        logic [2:0] row_lines;
        logic       keyboard_pa7;
        logic       keyboard_ca2;
        logic       host_byte_valid;
        logic [7:0] host_byte;
    } t_in_item;

    // The lines driven back onto the bus and the exchange with the host side.
    typedef struct packed {
        logic       pa7_out;
        logic       pa7_drive_on;
        logic       ca2_out;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       host_byte_taken;
    } t_out_item;

    // Hidden columns used for the byte exchange.
    localparam logic [3:0] COL_ACK       = 4'hA;
    localparam logic [3:0] COL_TX_DATA   = 4'hC;
    localparam logic [3:0] COL_TX_PREFIX = 4'hD;
    localparam logic [3:0] COL_RX_READ   = 4'hE;
    localparam logic [3:0] COL_STATUS    = 4'hF;

    // Columns up to this one belong to the real keyboard.
    localparam logic [3:0] COL_KEYS_MAX = 4'd9;

    // Status rows in the status column.
    localparam logic [2:0] ROW_RX_PENDING = 3'd7;
    localparam logic [2:0] ROW_TX_IDLE    = 3'd6;
    localparam logic [2:0] ROW_ACK        = 3'd0;

    // Markers for an address history that holds no valid entry.
    localparam logic [4:0] COL_INVALID = 5'd16;
    localparam logic [3:0] ROW_INVALID = 4'd8;

    function automatic logic [3:0] rev4(input logic [3:0] v);
        return {v[0], v[1], v[2], v[3]};
    endfunction

    function automatic logic [2:0] rev3(input logic [2:0] v);
        return {v[0], v[1], v[2]};
    endfunction

endpackage

// ----- src/kcsb_in_if.sv -----
interface kcsb_in_if;
    logic                valid;
    logic                ready;
    kcsb_pkg::t_in_item  data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- src/kcsb_out_if.sv -----
interface kcsb_out_if;
    logic                valid;
    logic                ready;
    kcsb_pkg::t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ----- src/kcsb_bus_core.sv -----
module kcsb_bus_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  kcsb_pkg::t_in_item  i_item,
    output kcsb_pkg::t_out_item o_result
);
    import kcsb_pkg::*;

    typedef struct packed {
        logic       clock_prev;
        logic [3:0] column_index;
        logic [2:0] row_index;
        logic [4:0] last_column;
        logic [3:0] last_row;
        logic [4:0] settled_column;
        logic [7:0] tx_shift;
        logic       tx_flag;
        logic       tx_ack_flag;
        logic [7:0] rx_byte;
        logic       rx_flag;
        logic       rx_ack_flag;
        logic       pa7_bit;
        logic       drive_latch;
    } t_state;

    t_state r_st;
    t_state n_st;

    logic       w_rising;
    logic [3:0] w_col;
    logic [2:0] w_row;
    logic       w_stable;

    assign w_rising = !r_st.clock_prev && i_item.clock_level;
    assign w_col    = rev4(i_item.column_lines);
    assign w_row    = rev3(i_item.row_lines);
    assign w_stable = (r_st.last_column == {1'b0, w_col}) && (r_st.last_row == {1'b0, w_row});

    always_comb begin
        n_st            = r_st;
        n_st.clock_prev = i_item.clock_level;
        o_result        = '0;

        if (w_rising) begin
            n_st.drive_latch = !i_item.scan_enable;
            if (i_item.scan_enable) begin
                n_st.column_index   = r_st.column_index + 4'd1;
                n_st.last_column    = COL_INVALID;
                n_st.last_row       = ROW_INVALID;
                n_st.settled_column = COL_INVALID;
            end else begin
                n_st.column_index = w_col;
                n_st.row_index    = w_row;
                n_st.pa7_bit      = 1'b0;
                if (w_stable) begin
                    if (w_col == COL_TX_DATA) begin
                        if (r_st.settled_column == {1'b0, COL_TX_PREFIX}) begin
                            n_st.tx_shift = {w_row, r_st.tx_shift[7:3]};
                        end
                    end else if (w_col == COL_ACK && w_row == ROW_ACK) begin
                        if (r_st.settled_column == {1'b0, COL_TX_DATA}) begin
                            n_st.tx_flag = !r_st.tx_ack_flag;
                            n_st.pa7_bit = 1'b1;
                        end else if (r_st.settled_column == {1'b0, COL_RX_READ}) begin
                            n_st.rx_ack_flag = r_st.rx_flag;
                            n_st.pa7_bit     = 1'b1;
                        end
                    end
                    n_st.settled_column = {1'b0, w_col};
                end
                if (w_col == COL_RX_READ) begin
                    n_st.pa7_bit = r_st.rx_byte[w_row];
                end else if (w_col == COL_STATUS) begin
                    if (w_row == ROW_RX_PENDING) begin
                        n_st.pa7_bit = (r_st.rx_flag != r_st.rx_ack_flag);
                    end else if (w_row == ROW_TX_IDLE) begin
                        n_st.pa7_bit = (r_st.tx_flag == r_st.tx_ack_flag);
                    end
                end
                n_st.last_column = {1'b0, w_col};
                n_st.last_row    = {1'b0, w_row};
            end
            if (n_st.column_index <= COL_KEYS_MAX) begin
                n_st.pa7_bit = 1'b0;
            end
        end

        // Host side sees the bus state after this beat's update.
        if (n_st.tx_flag != n_st.tx_ack_flag) begin
            o_result.tx_valid = 1'b1;
            o_result.tx_byte  = n_st.tx_shift;
            n_st.tx_ack_flag  = n_st.tx_flag;
        end
        if (n_st.rx_flag == n_st.rx_ack_flag && i_item.host_byte_valid) begin
            n_st.rx_byte             = i_item.host_byte;
            n_st.rx_flag             = !n_st.rx_ack_flag;
            o_result.host_byte_taken = 1'b1;
        end

        o_result.pa7_out      = n_st.pa7_bit
                              | (i_item.keyboard_pa7 && (n_st.column_index <= COL_KEYS_MAX));
        o_result.pa7_drive_on = n_st.drive_latch;
        o_result.ca2_out      = i_item.keyboard_ca2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    // A transmit request is always handed over in the beat that raises it.
    a_tx_never_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.tx_flag == r_st.tx_ack_flag)
        else $error("transmit toggle left pending");

    // A taken host byte leaves a receive byte pending for the bus side.
    a_rx_pending_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.host_byte_taken |=> r_st.rx_flag != r_st.rx_ack_flag)
        else $error("host byte taken but no receive pending");

    // The driven key bit only survives on hidden columns.
    a_pa7_bit_hidden_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.pa7_bit |-> r_st.column_index > COL_KEYS_MAX)
        else $error("own key bit set on a real keyboard column");

    // Without a processed beat the bus state does not move.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_st))
        else $error("bus state changed without a beat");

endmodule

// ----- src/keyboard_column_serial_bridge.sv -----
// Keyboard column serial bridge. Each input beat is one synchronized sample of the keyboard
// bus (clock, enable, column and row lines, the real keyboard's PA7 and CA2) together with a
// byte that the host serial side may offer; each input beat yields exactly one output beat
// carrying the driven PA7 level, the PA7 driver enable, CA2 passed through, an optional byte
// for the host and a flag that says whether the offered host byte was taken. A rising bus
// clock edge with enable high steps the column counter; with enable low the column and row
// are decoded by bit reversal, and a stable address on hidden columns D, C and A shifts row
// bits into a transmit byte and commits it, while columns E and F read back the receive byte
// and status. A beat is registered at the input, evaluated against the bus state and written
// to an output register, so the block sustains one beat per clock cycle while the output
// register is empty or drained; the only loop is the update of the bus state register.
// While the output register holds a beat that has not been taken, one more input beat is
// still accepted into the input register.
module keyboard_column_serial_bridge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    kcsb_in_if.sink           i_in,
    kcsb_out_if.source        o_out
);
    import kcsb_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item w_result;
    logic      w_step;

    // The input stage moves on whenever the output register is empty or being drained.
    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    // Bus state and the per-beat decode live in the core.
    kcsb_bus_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule
